// ----- hw/rtl/edb_pkg.sv -----
`timescale 1ns / 1ps
// shared widths, register indexes and arithmetic constants of the binariser
package edb_pkg;

    // field and store widths
    localparam int PIX_W      = 8;
    localparam int ERR_W      = 12;
    localparam int LW_W       = 12;
    localparam int SUM_W      = 14;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 1'd1;

    localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 12'd640;

    // threshold between dark and light
    localparam logic [SUM_W-1:0] DARK_LEVEL = 14'd255;

    // divide by 3 for sums up to 765: x * ceil(2^11 / 3) >> 11
    localparam int              DIV3_SH  = 11;
    localparam logic [9:0]      DIV3_MUL = 10'd683;

    // x / 22 as x * ceil(2^21 / 22) >> 21, exact for x below 104857
    // right and down share: 7 * 95326, diagonal share 2/11 = 4/22: 4 * 95326
    localparam int              MUL_W    = 20;
    localparam int              PROD_W   = SUM_W + MUL_W;
    localparam int              DIV22_SH = 21;
    localparam logic [MUL_W-1:0] R_MUL   = 20'd667282;
    localparam logic [MUL_W-1:0] Q_MUL   = 20'd381304;

endpackage

// ----- hw/rtl/edb_if.sv -----
`timescale 1ns / 1ps
// pixel input and dot output channel interfaces
interface edb_in_if;
    import edb_pkg::*;

    logic             valid;
    logic             ready;
    logic             frame_start;
    logic [PIX_W-1:0] red_or_gray;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (
        output valid, frame_start, red_or_gray, green, blue,
        input  ready
    );
    modport sink (
        input  valid, frame_start, red_or_gray, green, blue,
        output ready
    );
endinterface

interface edb_out_if;
    logic valid;
    logic ready;
    logic pixel_dark;

    modport source (
        output valid, pixel_dark,
        input  ready
    );
    modport sink (
        input  valid, pixel_dark,
        output ready
    );
endinterface

// ----- hw/rtl/error_diffusion_binarizer.sv -----
`timescale 1ns / 1ps
// Error-diffusion binariser: takes one 8-bit pixel (or an RGB triple averaged to gray) per
// item in raster order and returns one dot per item, 1 for dark. Sustained rate is one item
// per clock unless the output stalls. The rate is set by the line store of next-row errors,
// which sees one read (at accept) and one write per pixel; the row-end second write waits
// out any primary write, as at the following first-column pixel, which writes nothing.
// Columns still in flight are forwarded from the write registers. The line store holds
// MAX_WIDTH entries and is not cleared; a row is only read after the row above has been
// written. The user must write configuration only while idle, which is not enforced.
module error_diffusion_binarizer #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [edb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [edb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    edb_in_if.sink                          i_px,
    edb_out_if.source                       o_px
);
    import edb_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = (AW + 1 > LW_W) ? AW + 1 : LW_W;

    // configuration registers
    logic [LW_W-1:0]   r_line_width;
    logic              r_color_mode;

    // row position state
    logic [AW-1:0]     r_column;
    logic              r_above_valid;

    // compute stage
    logic              r_b_valid;
    logic [AW-1:0]     r_b_col;
    logic [PIX_W-1:0]  r_b_pix;
    logic              r_b_above_ok;
    logic              r_b_last;
    logic [ERR_W-1:0]  r_rdata;
    logic              r_fwd_valid;
    logic [ERR_W-1:0]  r_fwd_data;

    // row carries
    logic [ERR_W-1:0]  r_carry;
    logic [ERR_W-1:0]  r_pending_left;
    logic [ERR_W-1:0]  r_pending_here;

    // line store write registers
    logic              r_wa_valid;
    logic [AW-1:0]     r_wa_addr;
    logic [ERR_W-1:0]  r_wa_data;
    logic              r_wb_valid;
    logic [AW-1:0]     r_wb_addr;
    logic [ERR_W-1:0]  r_wb_data;

    // output register
    logic              r_out_valid;
    logic              r_out_dark;

    // line store
    logic [ERR_W-1:0]  mem [MAX_WIDTH];

    logic              acc;
    logic              b_fire;
    logic [WW-1:0]     lw_ext;
    logic [WW-1:0]     w_eff;
    logic [AW-1:0]     col_eff;
    logic              av_eff;
    logic              a_last;
    logic [AW-1:0]     n_column;
    logic [9:0]        rgb_sum;
    logic [19:0]       avg_prod;
    logic [PIX_W-1:0]  a_pix;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [ERR_W-1:0]  wdata;

    logic [ERR_W-1:0]  above_raw;
    logic [ERR_W-1:0]  above;
    logic              first;
    logic [ERR_W-1:0]  carry_in;
    logic [SUM_W-1:0]  sum;
    logic              b_dark;
    logic [SUM_W-1:0]  err;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] q_prod;
    logic [ERR_W-1:0]  r_share;
    logic [ERR_W-1:0]  q_share;
    logic [ERR_W-1:0]  pl_in;
    logic [ERR_W-1:0]  ph_in;
    logic [ERR_W-1:0]  w1_data;
    logic [ERR_W-1:0]  n_pl;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
            r_color_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LINE_WIDTH: r_line_width <= i_cfg_data[LW_W-1:0];
                REG_COLOR_MODE: r_color_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshakes
    assign acc        = i_px.valid && i_px.ready;
    assign b_fire     = r_b_valid && (!r_out_valid || o_px.ready);
    assign i_px.ready = !r_b_valid || b_fire;

    // clamp the row width into the store depth, a zero width counting as one
    assign lw_ext = WW'(r_line_width);
    always_comb begin
        w_eff = lw_ext;
        if (lw_ext == '0) begin
            w_eff = WW'(1);
        end else if (lw_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end
    end

    // column of the incoming item, restarting on frame start or a narrowed row
    always_comb begin
        col_eff = r_column;
        if (i_px.frame_start || WW'(r_column) >= w_eff) begin
            col_eff = '0;
        end
    end
    assign av_eff   = i_px.frame_start ? 1'b0 : r_above_valid;
    assign a_last   = (WW'(col_eff) == w_eff - WW'(1));
    assign n_column = a_last ? '0 : col_eff + AW'(1);

    // gray value, or channel average by reciprocal multiply
    assign rgb_sum  = 10'(i_px.red_or_gray) + 10'(i_px.green) + 10'(i_px.blue);
    assign avg_prod = rgb_sum * DIV3_MUL;
    assign a_pix    = r_color_mode ? avg_prod[DIV3_SH +: PIX_W] : i_px.red_or_gray;

    // row position update per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column      <= '0;
            r_above_valid <= 1'b0;
        end else if (acc) begin
            r_column      <= n_column;
            r_above_valid <= a_last ? 1'b1 : av_eff;
        end
    end

    // line store write port: the primary write wins, the row-end write waits while one is pending
    assign we    = r_wa_valid || r_wb_valid;
    assign waddr = r_wa_valid ? r_wa_addr : r_wb_addr;
    assign wdata = r_wa_valid ? r_wa_data : r_wb_data;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rdata <= mem[col_eff];
        end
    end

    // compute stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (acc) begin
            r_b_valid <= 1'b1;
        end else if (b_fire) begin
            r_b_valid <= 1'b0;
        end
    end

    // compute stage payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_col      <= col_eff;
            r_b_pix      <= a_pix;
            r_b_above_ok <= av_eff;
            r_b_last     <= a_last;
        end
    end

    // capture store writes that land after the read of the held column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (acc) begin
            r_fwd_valid <= we && (waddr == col_eff);
        end else if (we && (waddr == r_b_col)) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc || (we && (waddr == r_b_col))) begin
            r_fwd_data <= wdata;
        end
    end

    // error from the row above, newest copy first
    always_comb begin
        if (r_wa_valid && (r_wa_addr == r_b_col)) begin
            above_raw = r_wa_data;
        end else if (r_wb_valid && (r_wb_addr == r_b_col)) begin
            above_raw = r_wb_data;
        end else if (r_fwd_valid) begin
            above_raw = r_fwd_data;
        end else begin
            above_raw = r_rdata;
        end
    end
    assign above = r_b_above_ok ? above_raw : '0;

    // row carries read as zero on the first column
    assign first    = (r_b_col == '0);
    assign carry_in = first ? '0 : r_carry;
    assign pl_in    = first ? '0 : r_pending_left;
    assign ph_in    = first ? '0 : r_pending_here;

    // threshold and remainder
    assign sum    = SUM_W'(carry_in) + SUM_W'(r_b_pix) + SUM_W'(above);
    assign b_dark = (sum < DARK_LEVEL);
    assign err    = b_dark ? sum : sum - DARK_LEVEL;

    // shares of the remainder: 7/22 and 2/11
    assign r_prod  = PROD_W'(err) * PROD_W'(R_MUL);
    assign q_prod  = PROD_W'(err) * PROD_W'(Q_MUL);
    assign r_share = r_prod[DIV22_SH +: ERR_W];
    assign q_share = q_prod[DIV22_SH +: ERR_W];

    assign w1_data = pl_in + q_share;
    assign n_pl    = ph_in + r_share;

    // row carries update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry        <= '0;
            r_pending_left <= '0;
            r_pending_here <= '0;
        end else if (b_fire) begin
            r_carry        <= r_share;
            r_pending_left <= n_pl;
            r_pending_here <= q_share;
        end
    end

    // write register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa_valid <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            r_wa_valid <= b_fire && !first;
            if (b_fire && r_b_last) begin
                r_wb_valid <= 1'b1;
            end else if (!r_wa_valid) begin
                r_wb_valid <= 1'b0;
            end
        end
    end

    // write register payload
    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_wa_addr <= r_b_col - AW'(1);
            r_wa_data <= w1_data;
        end
        if (b_fire && r_b_last) begin
            r_wb_addr <= r_b_col;
            r_wb_data <= n_pl;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_px.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_out_dark <= b_dark;
        end
    end

    assign o_px.valid      = r_out_valid;
    assign o_px.pixel_dark = r_out_dark;

endmodule
